FILE: hdl/positional_list_engine_assert.svh
// Assertion macros for the checker module of the list engine.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list engine check failed");

// The consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list engine check failed");

`endif

FILE: hdl/ple_pkg.sv
`default_nettype none

package ple_pkg;

   // List geometry.
   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 16;
   localparam int LEN_W    = 7;
   localparam int KIND_W   = 3;
   localparam int STAT_W   = 2;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = POS_W + 1;

   // Read gather tree: leaves per first-level group.
   localparam int RT_FAN    = 8;
   localparam int RT_GROUPS = (CAPACITY + RT_FAN - 1) / RT_FAN;

   // Request kinds.
   localparam logic [KIND_W-1:0] REQ_READ   = 3'd0;
   localparam logic [KIND_W-1:0] REQ_FRONT  = 3'd1;
   localparam logic [KIND_W-1:0] REQ_BACK   = 3'd2;
   localparam logic [KIND_W-1:0] REQ_AT     = 3'd3;
   localparam logic [KIND_W-1:0] REQ_DELETE = 3'd4;

   // Result status codes.
   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]        req_type;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] item_value;
   } ple_request_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [STAT_W-1:0]        status;
      logic [LEN_W-1:0]         list_length;
   } ple_result_type;

   // What every cell does with its entry.
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_DELETE
   } ple_cmd_mode_type;

   // Command broadcast to the whole row of cells.
   typedef struct packed {
      ple_cmd_mode_type  mode;
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] value;
   } ple_cell_cmd_type;

endpackage

`default_nettype wire

FILE: hdl/ple_cell.sv
`default_nettype none

module ple_cell import ple_pkg::*; (
   input  wire logic             clock,
   input  wire ple_cell_cmd_type cmd,
   input  wire logic [IDX_W-1:0] cell_index,
   input  wire logic [DATA_W-1:0] prev_data,
   input  wire logic [DATA_W-1:0] next_data,
   output logic [DATA_W-1:0]     data_out,
   output logic [DATA_W-1:0]     sel_data
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // An insert shifts entries above the slot up by one; a delete pulls them down.
   always_comb begin
      data_in = data_ff;
      unique case (cmd.mode)
         CMD_INSERT: begin
            if (cell_index > cmd.index) begin
               data_in = prev_data;
            end else if (cell_index == cmd.index) begin
               data_in = cmd.value;
            end
         end
         CMD_DELETE: begin
            if (cell_index >= cmd.index) begin
               data_in = next_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // The addressed cell offers its entry to the read tree, all others offer zero.
   assign data_out = data_ff;
   assign sel_data = (cell_index == cmd.index) ? data_ff : '0;

endmodule

`default_nettype wire

FILE: hdl/ple_read_tree.sv
`default_nettype none

module ple_read_tree import ple_pkg::*; (
   input  wire logic              clock,
   input  wire logic [DATA_W-1:0] leaf_data [CAPACITY],
   output logic [DATA_W-1:0]      or_value
);

   logic [DATA_W-1:0] group_in [RT_GROUPS];
   logic [DATA_W-1:0] group_ff [RT_GROUPS];

   // First level: OR each group of leaves.
   always_comb begin
      for (int g = 0; g < RT_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < RT_FAN; k++) begin
            if (g * RT_FAN + k < CAPACITY) begin
               group_in[g] = group_in[g] | leaf_data[g * RT_FAN + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   // Second level: OR the registered groups.
   always_comb begin
      or_value = '0;
      for (int g = 0; g < RT_GROUPS; g++) begin
         or_value = or_value | group_ff[g];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/positional_list_engine.sv
`default_nettype none
// Positional list engine: an ordered list of up to CAPACITY 32-bit entries.
// A transaction is accepted at a rising edge with start high and busy low;
// req_item carries the kind (read, insert front, insert back, insert at a
// position, delete at a position), the position and the value to insert.
// After acceptance rsp_strobe is high for exactly one cycle and
// rsp_item holds the read value (zero unless a read succeeds), the status
// (done, position out of range, list full) and the length after the request.
// busy is high from acceptance until the result cycle, so a new transaction
// may be accepted in the cycle that carries the previous result, but not
// earlier. The path runs through the command register, then the shift of the
// cell row together with the first level of the read tree, and then the
// second level of the read tree into the result register.
// Entries live in a row of cells; each cell compares its own index with the
// broadcast position and takes its own, its lower or its upper neighbor's
// entry or the inserted value, so an insert or delete moves the whole list at once.
// Reset empties the list at once; cell contents are not cleared and are
// never read beyond the length. The receiver cannot stall the result.
module positional_list_engine import ple_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire ple_request_type req_item,
   output logic                 rsp_strobe,
   output ple_result_type       rsp_item
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_GATHER
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   ple_request_type      req_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [STAT_W-1:0]    status_ff;
   logic [STAT_W-1:0]    status_in;
   logic                 hit_ff;
   logic                 hit_in;
   logic [LEN_W-1:0]     len_ff;
   logic                 rsp_strobe_ff;
   ple_result_type       rsp_item_ff;
   ple_cell_cmd_type     cell_cmd;
   logic                 accept;
   logic [CMP_W-1:0]     pos_cmp;
   logic [CMP_W-1:0]     count_cmp;
   logic                 is_full;
   logic [DATA_W-1:0]    cell_data [CAPACITY];
   logic [DATA_W-1:0]    sel_data [CAPACITY];
   logic [DATA_W-1:0]    tree_value;

   assign accept    = start && (state_ff == S_IDLE);
   assign pos_cmp   = CMP_W'(req_ff.position);
   assign count_cmp = CMP_W'(count_ff);
   assign is_full   = (count_ff == CNT_W'(CAPACITY));

   // Decode the held transaction into a status, a new length and a cell command.
   always_comb begin
      status_in      = STAT_DONE;
      hit_in         = 1'b0;
      count_in       = count_ff;
      cell_cmd.mode  = CMD_HOLD;
      cell_cmd.index = IDX_W'(req_ff.position);
      cell_cmd.value = req_ff.item_value;
      unique case (req_ff.req_type) inside
         REQ_READ: begin
            if (pos_cmp < count_cmp) begin
               hit_in = 1'b1;
            end else begin
               status_in = STAT_RANGE;
            end
         end
         REQ_FRONT, REQ_BACK, REQ_AT: begin
            if (req_ff.req_type == REQ_FRONT) begin
               cell_cmd.index = '0;
            end else if (req_ff.req_type == REQ_BACK) begin
               cell_cmd.index = IDX_W'(count_ff);
            end
            if (req_ff.req_type == REQ_AT && pos_cmp > count_cmp) begin
               status_in = STAT_RANGE;
            end else if (is_full) begin
               status_in = STAT_FULL;
            end else begin
               cell_cmd.mode = CMD_INSERT;
               count_in      = count_ff + CNT_W'(1);
            end
         end
         REQ_DELETE: begin
            if (pos_cmp < count_cmp) begin
               cell_cmd.mode = CMD_DELETE;
               count_in      = count_ff - CNT_W'(1);
            end else begin
               status_in = STAT_RANGE;
            end
         end
         default: begin
            status_in = STAT_DONE;
         end
      endcase
      if (state_ff != S_EXEC) begin
         cell_cmd.mode = CMD_HOLD;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   state_in = accept ? S_EXEC : S_IDLE;
         S_EXEC:   state_in = S_GATHER;
         S_GATHER: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Control state, the held transaction and the result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == S_GATHER);
         if (accept) begin
            req_ff <= req_item;
         end
         if (state_ff == S_EXEC) begin
            count_ff  <= count_in;
            status_ff <= status_in;
            hit_ff    <= hit_in;
            len_ff    <= LEN_W'(count_in);
         end
         if (state_ff == S_GATHER) begin
            rsp_item_ff.read_value  <= hit_ff ? tree_value : '0;
            rsp_item_ff.status      <= status_ff;
            rsp_item_ff.list_length <= len_ff;
         end
      end
   end

   // The row of cells; the ends see the inserted value and zero.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] prev_data;
      logic [DATA_W-1:0] next_data;
      if (i == 0) begin : g_first
         assign prev_data = cell_cmd.value;
      end else begin : g_inner_prev
         assign prev_data = cell_data[i - 1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_data = '0;
      end else begin : g_inner_next
         assign next_data = cell_data[i + 1];
      end
      ple_cell u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .cell_index (IDX_W'(i)),
         .prev_data  (prev_data),
         .next_data  (next_data),
         .data_out   (cell_data[i]),
         .sel_data   (sel_data[i])
      );
   end

   ple_read_tree u_read_tree (
      .clock     (clock),
      .leaf_data (sel_data),
      .or_value  (tree_value)
   );

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

`default_nettype wire

FILE: hdl/ple_checker.sv
`default_nettype none
`include "positional_list_engine_assert.svh"

module ple_checker import ple_pkg::*; (
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            start,
   input wire logic            busy,
   input wire logic            rsp_strobe,
   input wire ple_result_type  rsp_item
);

   logic accepted;

   // A transaction is taken when start meets an idle engine.
   assign accepted = start && !busy;

   // An accepted transaction makes the engine busy in the next cycle.
   `PLE_ASSERT_NEXT(a_busy_after_accept, clock, reset, accepted, busy)
   // Every accepted transaction is followed by its result strobe.
   `PLE_ASSERT_NOW(a_result_latency, clock, reset, accepted, ##3 rsp_strobe)
   // Results never come in consecutive cycles.
   `PLE_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe)
   // A request that does not complete carries a zero value.
   `PLE_ASSERT_NOW(a_value_zero_on_error, clock, reset,
      rsp_strobe && rsp_item.status != STAT_DONE, rsp_item.read_value == '0)

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);

`default_nettype wire
